// ===== hdl/imbe_pkg.sv =====
// ----------------------------------------------------------------------------
// imbe_pkg: shared types and constants of the I2C master bit engine
// Phase codes, command codes, register indexes, state and configuration
// records, and the line-drive lookup used when a phase is entered.
// ----------------------------------------------------------------------------
package imbe_pkg;

  // Bus phases of the engine
  typedef enum logic [4:0] {
    PH_IDLE    = 5'd0,
    PH_ST_REL  = 5'd1,
    PH_ST_SDA  = 5'd2,
    PH_ST_SCL  = 5'd3,
    PH_SP_LOW  = 5'd4,
    PH_SP_SCL  = 5'd5,
    PH_SP_SDA  = 5'd6,
    PH_WR_PRE  = 5'd7,
    PH_WR_DAT  = 5'd8,
    PH_WR_HI   = 5'd9,
    PH_WR_LO   = 5'd10,
    PH_AK_REL  = 5'd11,
    PH_AK_HI   = 5'd12,
    PH_AK_POLL = 5'd13,
    PH_AK_LO   = 5'd14,
    PH_RD_LO   = 5'd15,
    PH_RD_HI   = 5'd16,
    PH_RD_KEEP = 5'd17,
    PH_RD_END  = 5'd18,
    PH_KA_DAT  = 5'd19,
    PH_KA_HI   = 5'd20,
    PH_KA_LO   = 5'd21,
    PH_RC_REL  = 5'd22,
    PH_RC_LO   = 5'd23,
    PH_RC_HI   = 5'd24
  } phase_e;

  // Command codes
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_START   = 3'd1;
  localparam logic [2:0] OP_WRITE   = 3'd2;
  localparam logic [2:0] OP_READ    = 3'd3;
  localparam logic [2:0] OP_STOP    = 3'd4;
  localparam logic [2:0] OP_RECOVER = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_PHASE_TICKS   = 2'd0;
  localparam logic [1:0] CFG_ACK_TIMEOUT   = 2'd1;
  localparam logic [1:0] CFG_STRETCH_GUARD = 2'd2;

  // Register reset values
  localparam logic [7:0]  PHASE_TICKS_RST   = 8'd5;
  localparam logic [15:0] ACK_TIMEOUT_RST   = 16'd300;
  localparam logic [15:0] STRETCH_GUARD_RST = 16'd1000;

  // Counts
  localparam logic [3:0] BITS_PER_BYTE   = 4'd8;
  localparam logic [3:0] RECOVER_PULSES  = 4'd9;

  // Line drive: bit 0 pulls SCL low, bit 1 pulls SDA low
  localparam logic [1:0] LINES_RELEASED = 2'b00;

  typedef struct packed {
    phase_e      phase;
    logic [3:0]  bit_count;
    logic [7:0]  shift_reg;
    logic [7:0]  phase_timer;
    logic [15:0] ack_timer;
    logic [15:0] stretch_timer;
    logic        ack_choice;
    logic [1:0]  line_drive;
    logic        last_status;
    logic [7:0]  rx_keep;
  } imbe_state_t;

  typedef struct packed {
    logic [7:0]  phase_ticks;
    logic [15:0] ack_timeout_ticks;
    logic [15:0] stretch_guard_ticks;
  } imbe_cfg_t;

  // Line drive on entry to a phase; phases not listed keep the current drive
  function automatic logic [1:0] phase_lines(phase_e p, logic data_msb,
                                             logic ack_choice, logic [1:0] cur);
    logic [1:0] lines;
    lines = cur;
    case (p)
      PH_ST_REL, PH_SP_SDA, PH_AK_HI, PH_RD_HI,
      PH_RD_KEEP, PH_RC_REL, PH_RC_HI:           lines = 2'b00;
      PH_ST_SDA, PH_SP_SCL:                      lines = 2'b10;
      PH_ST_SCL, PH_SP_LOW:                      lines = 2'b11;
      PH_WR_PRE, PH_AK_REL, PH_AK_LO, PH_RD_LO,
      PH_RD_END, PH_KA_LO, PH_RC_LO:             lines = 2'b01;
      PH_WR_DAT:                                 lines = {~data_msb, 1'b1};
      PH_WR_HI:                                  lines = {cur[1], 1'b0};
      PH_WR_LO:                                  lines = {cur[1], 1'b1};
      PH_KA_DAT:                                 lines = {ack_choice, 1'b1};
      PH_KA_HI:                                  lines = {ack_choice, 1'b0};
      default:                                   lines = cur;
    endcase
    return lines;
  endfunction

endpackage

// ===== hdl/imbe_step.sv =====
// ----------------------------------------------------------------------------
// imbe_step: one-tick next-state logic of the I2C master bit engine
// Takes the current engine state, the configuration and one tick's command
// and line samples, and gives the state after the tick and the done flag.
// ----------------------------------------------------------------------------
module imbe_step (
  input  imbe_pkg::imbe_state_t state_i,
  input  imbe_pkg::imbe_cfg_t   cfg_i,
  input  logic [2:0]            op_i,
  input  logic [7:0]            tx_byte_i,
  input  logic                  send_ack_i,
  input  logic                  scl_in_i,
  input  logic                  sda_in_i,
  output imbe_pkg::imbe_state_t state_o,
  output logic                  done_o
);

  imbe_pkg::imbe_state_t nxt;
  imbe_pkg::phase_e      enter_ph;
  logic                  enter_en;
  logic                  done;
  logic [7:0]            pt_inc;
  logic [7:0]            limit;
  logic [15:0]           ack_inc;
  logic [3:0]            bc_inc;
  logic                  rel_scl;

  assign pt_inc  = state_i.phase_timer + 8'd1;
  assign ack_inc = state_i.ack_timer + 16'd1;
  assign bc_inc  = state_i.bit_count + 4'd1;
  assign limit   = (state_i.phase == imbe_pkg::PH_AK_REL) ? 8'd1 : cfg_i.phase_ticks;
  assign rel_scl = state_i.phase inside {imbe_pkg::PH_SP_SCL, imbe_pkg::PH_WR_HI,
                                         imbe_pkg::PH_AK_HI, imbe_pkg::PH_RD_HI,
                                         imbe_pkg::PH_KA_HI, imbe_pkg::PH_RC_HI};

  // Advance the engine by one tick
  always_comb begin
    nxt      = state_i;
    enter_en = 1'b0;
    enter_ph = imbe_pkg::PH_IDLE;
    done     = 1'b0;

    if (state_i.phase == imbe_pkg::PH_IDLE) begin
      // take a command
      if (op_i inside {[imbe_pkg::OP_START:imbe_pkg::OP_RECOVER]}) begin
        nxt.last_status = 1'b0;
      end
      case (op_i)
        imbe_pkg::OP_START: begin
          enter_en = 1'b1;
          enter_ph = imbe_pkg::PH_ST_REL;
        end
        imbe_pkg::OP_WRITE: begin
          nxt.shift_reg = tx_byte_i;
          enter_en      = 1'b1;
          enter_ph      = imbe_pkg::PH_WR_PRE;
        end
        imbe_pkg::OP_READ: begin
          nxt.ack_choice = send_ack_i;
          nxt.shift_reg  = 8'd0;
          nxt.bit_count  = 4'd0;
          enter_en       = 1'b1;
          enter_ph       = imbe_pkg::PH_RD_LO;
        end
        imbe_pkg::OP_STOP: begin
          enter_en = 1'b1;
          enter_ph = imbe_pkg::PH_SP_LOW;
        end
        imbe_pkg::OP_RECOVER: begin
          enter_en = 1'b1;
          enter_ph = imbe_pkg::PH_RC_REL;
        end
        default: ;
      endcase
    end else if (state_i.phase == imbe_pkg::PH_AK_POLL) begin
      // poll for ACK, give up after the timeout
      if (!sda_in_i) begin
        enter_en = 1'b1;
        enter_ph = imbe_pkg::PH_AK_LO;
      end else begin
        nxt.ack_timer = ack_inc;
        if (ack_inc >= cfg_i.ack_timeout_ticks) begin
          nxt.last_status = 1'b1;
          enter_en        = 1'b1;
          enter_ph        = imbe_pkg::PH_SP_LOW;
        end
      end
    end else if (rel_scl && state_i.phase_timer == 8'd0 && !scl_in_i &&
                 state_i.stretch_timer < cfg_i.stretch_guard_ticks) begin
      // hold while a slave stretches the clock
      nxt.stretch_timer = state_i.stretch_timer + 16'd1;
    end else begin
      nxt.phase_timer = pt_inc;
      if (pt_inc >= limit || pt_inc == 8'd0) begin
        // end the held phase
        enter_en = 1'b1;
        case (state_i.phase)
          imbe_pkg::PH_ST_REL: enter_ph = imbe_pkg::PH_ST_SDA;
          imbe_pkg::PH_ST_SDA: enter_ph = imbe_pkg::PH_ST_SCL;
          imbe_pkg::PH_SP_LOW: enter_ph = imbe_pkg::PH_SP_SCL;
          imbe_pkg::PH_SP_SCL: enter_ph = imbe_pkg::PH_SP_SDA;
          imbe_pkg::PH_WR_PRE: begin
            nxt.bit_count = 4'd0;
            enter_ph      = imbe_pkg::PH_WR_DAT;
          end
          imbe_pkg::PH_WR_DAT: enter_ph = imbe_pkg::PH_WR_HI;
          imbe_pkg::PH_WR_HI:  enter_ph = imbe_pkg::PH_WR_LO;
          imbe_pkg::PH_WR_LO: begin
            nxt.shift_reg = {state_i.shift_reg[6:0], 1'b0};
            nxt.bit_count = bc_inc;
            enter_ph      = (bc_inc >= imbe_pkg::BITS_PER_BYTE) ?
                            imbe_pkg::PH_AK_REL : imbe_pkg::PH_WR_DAT;
          end
          imbe_pkg::PH_AK_REL: enter_ph = imbe_pkg::PH_AK_HI;
          imbe_pkg::PH_AK_HI: begin
            nxt.ack_timer = 16'd0;
            enter_ph      = imbe_pkg::PH_AK_POLL;
          end
          imbe_pkg::PH_RD_LO: enter_ph = imbe_pkg::PH_RD_HI;
          imbe_pkg::PH_RD_HI: begin
            nxt.shift_reg = {state_i.shift_reg[6:0], sda_in_i};
            enter_ph      = imbe_pkg::PH_RD_KEEP;
          end
          imbe_pkg::PH_RD_KEEP: begin
            nxt.bit_count = bc_inc;
            enter_ph      = (bc_inc >= imbe_pkg::BITS_PER_BYTE) ?
                            imbe_pkg::PH_RD_END : imbe_pkg::PH_RD_LO;
          end
          imbe_pkg::PH_RD_END: enter_ph = imbe_pkg::PH_KA_DAT;
          imbe_pkg::PH_KA_DAT: enter_ph = imbe_pkg::PH_KA_HI;
          imbe_pkg::PH_KA_HI:  enter_ph = imbe_pkg::PH_KA_LO;
          imbe_pkg::PH_RC_REL: begin
            nxt.bit_count = 4'd0;
            enter_ph      = sda_in_i ? imbe_pkg::PH_SP_LOW : imbe_pkg::PH_RC_LO;
          end
          imbe_pkg::PH_RC_LO: enter_ph = imbe_pkg::PH_RC_HI;
          imbe_pkg::PH_RC_HI: begin
            nxt.bit_count = bc_inc;
            enter_ph      = (bc_inc >= imbe_pkg::RECOVER_PULSES) ?
                            imbe_pkg::PH_SP_LOW : imbe_pkg::PH_RC_LO;
          end
          imbe_pkg::PH_KA_LO: begin
            nxt.rx_keep = state_i.shift_reg;
            enter_ph    = imbe_pkg::PH_IDLE;
            done        = 1'b1;
          end
          default: begin
            enter_ph = imbe_pkg::PH_IDLE;
            done     = 1'b1;
          end
        endcase
      end
    end

    // enter the new phase: clear the phase and stretch timers, set the line drive
    if (enter_en) begin
      nxt.phase         = enter_ph;
      nxt.phase_timer   = 8'd0;
      nxt.stretch_timer = 16'd0;
      nxt.line_drive    = imbe_pkg::phase_lines(enter_ph, nxt.shift_reg[7],
                                                nxt.ack_choice, state_i.line_drive);
    end
  end

  assign state_o = nxt;
  assign done_o  = done;

endmodule

// ===== hdl/i2c_master_bit_engine.sv =====
// ----------------------------------------------------------------------------
// i2c_master_bit_engine: tick-level open-drain I2C master
// Input register, one-tick engine step and result register with stall.
// ----------------------------------------------------------------------------
// Usage:
//   Each input word is one bus timing tick: a command (op_i with tx_byte_i
//   and send_ack_i) plus the sampled SCL and SDA levels. Every accepted word
//   yields exactly one result word: line drives, busy, done, rx_byte, status.
//   Words move on valid/stall: a word is taken at a clock edge with valid
//   high and stall low. Commands given while busy are ignored.
//   An accepted word sits in the input register, and the engine step loads
//   the result register from it once the result slot is free. Throughput
//   is one word per cycle while out_stall_i holds no pending result; the
//   engine state loop closes through one step each cycle.
//   When out_stall_i holds a pending result, the engine and input register
//   hold; in_stall_o rises once the input register is also occupied.
//   Reset clears both pipeline valids, puts the engine in idle with both
//   lines released, and loads the timing registers with their defaults.
//   Write configuration through cfg_we_i only while no word is in flight.
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  op_i,
  input  logic [7:0]  tx_byte_i,
  input  logic        send_ack_i,
  input  logic        scl_in_i,
  input  logic        sda_in_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        scl_low_o,
  output logic        sda_low_o,
  output logic        busy_res_o,
  output logic        done_res_o,
  output logic [7:0]  rx_byte_o,
  output logic        status_o
);

  logic                  in_vld_q, in_vld_d;
  logic [2:0]            op_q;
  logic [7:0]            tx_byte_q;
  logic                  send_ack_q, scl_in_q, sda_in_q;
  logic                  out_vld_q, out_vld_d;
  logic                  scl_low_q, sda_low_q, busy_q, done_q, status_q;
  logic [7:0]            rx_byte_q;
  logic                  advance, accept_in, step_done;
  imbe_pkg::imbe_state_t state_q, state_d;
  imbe_pkg::imbe_cfg_t   cfg_q;

  // Handshake: step when a word waits and the result slot frees up
  assign advance   = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept_in = in_valid_i && !in_stall_o;
  assign in_vld_d  = accept_in || (in_vld_q && !advance);
  assign out_vld_d = advance || (out_vld_q && out_stall_i);

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.phase_ticks         <= imbe_pkg::PHASE_TICKS_RST;
      cfg_q.ack_timeout_ticks   <= imbe_pkg::ACK_TIMEOUT_RST;
      cfg_q.stretch_guard_ticks <= imbe_pkg::STRETCH_GUARD_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        imbe_pkg::CFG_PHASE_TICKS:   cfg_q.phase_ticks         <= cfg_wdata_i[7:0];
        imbe_pkg::CFG_ACK_TIMEOUT:   cfg_q.ack_timeout_ticks   <= cfg_wdata_i;
        imbe_pkg::CFG_STRETCH_GUARD: cfg_q.stretch_guard_ticks <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Input register
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      op_q       <= op_i;
      tx_byte_q  <= tx_byte_i;
      send_ack_q <= send_ack_i;
      scl_in_q   <= scl_in_i;
      sda_in_q   <= sda_in_i;
    end
  end

  // Engine step
  imbe_step u_step (
    .state_i    (state_q),
    .cfg_i      (cfg_q),
    .op_i       (op_q),
    .tx_byte_i  (tx_byte_q),
    .send_ack_i (send_ack_q),
    .scl_in_i   (scl_in_q),
    .sda_in_i   (sda_in_q),
    .state_o    (state_d),
    .done_o     (step_done)
  );

  // Engine state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= imbe_pkg::PH_IDLE;
      state_q.bit_count     <= 4'd0;
      state_q.shift_reg     <= 8'd0;
      state_q.phase_timer   <= 8'd0;
      state_q.ack_timer     <= 16'd0;
      state_q.stretch_timer <= 16'd0;
      state_q.ack_choice    <= 1'b0;
      state_q.line_drive    <= imbe_pkg::LINES_RELEASED;
      state_q.last_status   <= 1'b0;
      state_q.rx_keep       <= 8'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (advance) begin
      scl_low_q <= state_d.line_drive[0];
      sda_low_q <= state_d.line_drive[1];
      busy_q    <= (state_d.phase != imbe_pkg::PH_IDLE);
      done_q    <= step_done;
      rx_byte_q <= state_d.rx_keep;
      status_q  <= state_d.last_status;
    end
  end

  assign out_valid_o = out_vld_q;
  assign scl_low_o   = scl_low_q;
  assign sda_low_o   = sda_low_q;
  assign busy_res_o  = busy_q;
  assign done_res_o  = done_q;
  assign rx_byte_o   = rx_byte_q;
  assign status_o    = status_q;

endmodule
